// ----- design/xlr_pkg.sv -----
// xlr_pkg: shared types, constants and the xorshift helper function of the
// xorshift/lcg range random block. No dependencies.
package xlr_pkg;

   // widths
   localparam int GEN_W = 64;   // generator word
   localparam int VAL_W = 33;   // signed value and bound fields
   localparam int RAW_W = 32;   // raw value taken from the word
   localparam int MUL_W = 17;   // multiplier constant width
   localparam int PLO_W = RAW_W + MUL_W;

   // generator constants
   localparam int SHIFT_A = 13;
   localparam int SHIFT_B = 17;
   localparam int SHIFT_C = 5;
   localparam logic [MUL_W-1:0] MIX_MUL = MUL_W'(69069);
   localparam logic [GEN_W-1:0] MIX_ADD = GEN_W'(12345);
   localparam int WARMUP = 7;
   localparam int WARM_W = $clog2(WARMUP + 1);

   // default request queue depth
   localparam int QUEUE_DEPTH_DEF = 2;

   // request type codes
   localparam logic REQ_RAW     = 1'b0;
   localparam logic REQ_BOUNDED = 1'b1;

   // request class as decided by the front end
   typedef enum logic [1:0] {
      CLS_RAW,
      CLS_BOUNDED,
      CLS_BAD
   } class_type;

   // one queued request
   typedef struct packed {
      class_type        cls;
      logic [VAL_W-1:0] span;
      logic [VAL_W-1:0] lower;
   } job_type;

   // back end sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MIX,
      ST_MUL,
      ST_ADD,
      ST_DIV,
      ST_DONE
   } state_type;

   // the three shift-xor steps of one advance
   function automatic logic [GEN_W-1:0] xorshift(input logic [GEN_W-1:0] w);
      logic [GEN_W-1:0] t;
      t = w ^ (w << SHIFT_A);
      t = t ^ (t >> SHIFT_B);
      t = t ^ (t << SHIFT_C);
      return t;
   endfunction

endpackage

// ----- design/xorshift_lcg_range_random.sv -----
// xorshift_lcg_range_random: top level of the range random block.
// Depends on xlr_pkg, xlr_front, xlr_queue and xlr_back.
//
//  channel  ports                                  handshake
//  request  req_type, req_lower_bound/upper_bound  req_valid / req_ready
//  response rsp_value, rsp_bound_error             rsp_valid / rsp_ready
//  config   csr_wr_data (64-bit seed)              csr_wr_en, no wait
//
// raw request: from queue head through the advance unit (xorshift, two
// 32x17 partial products, add) to the response; bounded: the same advance,
// then the restoring remainder unit, one bit a cycle; bad bounds: no advance.
// reset and each seed write crank the word 7 times; requests queue up
// meanwhile. the queue lets requests in while a response waits.
module xorshift_lcg_range_random
   import xlr_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_type,
   input  logic [VAL_W-1:0] req_lower_bound,
   input  logic [VAL_W-1:0] req_upper_bound,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [VAL_W-1:0] rsp_value,
   output logic             rsp_bound_error,
   input  logic             csr_wr_en,
   input  logic [GEN_W-1:0] csr_wr_data
);

   logic    push;
   job_type push_job;
   logic    pop;
   job_type pop_job;
   logic    q_full;
   logic    q_empty;

   // request classification
   xlr_front u_front (
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_lower_bound (req_lower_bound),
      .req_upper_bound (req_upper_bound),
      .q_full          (q_full),
      .push            (push),
      .push_job        (push_job)
   );

   // request queue
   xlr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .full     (q_full),
      .empty    (q_empty)
   );

   // generator and remainder back end
   xlr_back u_back (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .q_empty         (q_empty),
      .q_job           (pop_job),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_value       (rsp_value),
      .rsp_bound_error (rsp_bound_error)
   );

endmodule

// ----- design/xlr_front.sv -----
// xlr_front: accepts requests, checks the bounds and works out the span,
// then pushes the classified request into the queue. Uses xlr_pkg.
module xlr_front
   import xlr_pkg::*;
(
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_type,
   input  logic [VAL_W-1:0] req_lower_bound,
   input  logic [VAL_W-1:0] req_upper_bound,
   input  logic             q_full,
   output logic             push,
   output job_type          push_job
);

   logic bad_bounds;

   // signed order over the full 33-bit range
   assign bad_bounds = $signed(req_lower_bound) >= $signed(req_upper_bound);

   // accept whenever the queue has room
   assign req_ready = !q_full;
   assign push      = req_valid && !q_full;

   // classify the request
   always_comb begin
      push_job.span  = req_upper_bound - req_lower_bound;
      push_job.lower = req_lower_bound;
      unique case (req_type)
         REQ_RAW: begin
            push_job.cls = CLS_RAW;
         end
         REQ_BOUNDED: begin
            push_job.cls = bad_bounds ? CLS_BAD : CLS_BOUNDED;
         end
         default: begin
            push_job.cls = CLS_RAW;
         end
      endcase
   end

endmodule

// ----- design/xlr_queue.sv -----
// xlr_queue: short request queue between front and back end.
// Uses job_type from xlr_pkg.
module xlr_queue
   import xlr_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type pop_job,
   output logic    full,
   output logic    empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full    = count_ff == CNT_W'(DEPTH);
   assign empty   = count_ff == '0;
   assign pop_job = slot_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("request pushed into a full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("request popped from an empty queue");
`endif

endmodule

// ----- design/xlr_back.sv -----
// xlr_back: generator word, shared advance unit, restoring remainder unit
// and the response register. Uses xlr_pkg.
module xlr_back
   import xlr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [GEN_W-1:0] csr_wr_data,
   input  logic             q_empty,
   input  job_type          q_job,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [VAL_W-1:0] rsp_value,
   output logic             rsp_bound_error
);

   localparam int DCNT_W = $clog2(RAW_W);

   state_type          state_ff, state_in;
   logic [WARM_W-1:0]  warm_ff, warm_in;
   logic [GEN_W-1:0]   gen_ff, gen_in;
   logic [PLO_W-1:0]   plo_ff;
   logic [RAW_W-1:0]   phi_ff;
   job_type            job_ff;
   logic [RAW_W-1:0]   dvd_ff;
   logic [VAL_W-1:0]   rem_ff, rem_in;
   logic [DCNT_W-1:0]  dcnt_ff;
   logic               rsp_valid_ff;
   logic [VAL_W-1:0]   rsp_value_ff, rsp_value_in;
   logic               rsp_error_ff, rsp_error_in;

   logic               out_free;
   logic               out_load;
   logic               div_last;
   logic [GEN_W-1:0]   sum;
   logic [VAL_W:0]     shifted;
   logic [VAL_W:0]     span_ext;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign div_last = dcnt_ff == DCNT_W'(RAW_W - 1);

   // multiply-add: low partial product plus high partial product shifted up
   assign sum = GEN_W'(plo_ff) + {phi_ff, {RAW_W{1'b0}}} + MIX_ADD;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   assign shifted  = {rem_ff, dvd_ff[RAW_W-1]};
   assign span_ext = {1'b0, job_ff.span};
   always_comb begin
      if (shifted >= span_ext) begin
         rem_in = VAL_W'(shifted - span_ext);
      end else begin
         rem_in = shifted[VAL_W-1:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               state_in = (q_job.cls == CLS_BAD) ? ST_DONE : ST_MIX;
            end
         end
         ST_MIX: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_ADD;
         end
         ST_ADD: begin
            if (warm_ff != '0) begin
               state_in = (warm_ff == WARM_W'(1)) ? ST_IDLE : ST_MIX;
            end else if (job_ff.cls == CLS_BOUNDED) begin
               state_in = ST_DIV;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DIV: begin
            if (div_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // a seed write restarts the warm-up cranks
      if (csr_wr_en) begin
         state_in = ST_MIX;
      end
   end

   // control outputs
   always_comb begin
      pop      = (state_ff == ST_IDLE) && !q_empty && !csr_wr_en;
      out_load = (state_ff == ST_DONE) && out_free;
   end

   // generator word and warm-up count
   always_comb begin
      gen_in  = gen_ff;
      warm_in = warm_ff;
      if (csr_wr_en) begin
         gen_in  = csr_wr_data;
         warm_in = WARM_W'(WARMUP);
      end else if (state_ff == ST_MIX) begin
         gen_in = xorshift(gen_ff);
      end else if (state_ff == ST_ADD) begin
         gen_in = sum;
         if (warm_ff != '0) begin
            warm_in = warm_ff - 1'b1;
         end
      end
   end

   // response contents
   always_comb begin
      unique case (job_ff.cls)
         CLS_RAW: begin
            rsp_value_in = {1'b0, gen_ff[RAW_W-1:0]};
            rsp_error_in = 1'b0;
         end
         CLS_BOUNDED: begin
            rsp_value_in = rem_ff + job_ff.lower;
            rsp_error_in = 1'b0;
         end
         CLS_BAD: begin
            rsp_value_in = '0;
            rsp_error_in = 1'b1;
         end
         default: begin
            rsp_value_in = '0;
            rsp_error_in = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_MIX;
         warm_ff      <= WARM_W'(WARMUP);
         gen_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         warm_ff  <= warm_in;
         gen_ff   <= gen_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff <= q_job;
      end
      // partial products of the 69069 multiply
      if (state_ff == ST_MUL) begin
         plo_ff <= gen_ff[RAW_W-1:0] * MIX_MUL;
         phi_ff <= RAW_W'(gen_ff[GEN_W-1:RAW_W] * MIX_MUL);
      end
      // remainder unit
      if (state_ff == ST_ADD) begin
         dvd_ff  <= sum[RAW_W-1:0];
         rem_ff  <= '0;
         dcnt_ff <= '0;
      end else if (state_ff == ST_DIV) begin
         dvd_ff  <= dvd_ff << 1;
         rem_ff  <= rem_in;
         dcnt_ff <= dcnt_ff + 1'b1;
      end
      if (out_load) begin
         rsp_value_ff <= rsp_value_in;
         rsp_error_ff <= rsp_error_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_value       = rsp_value_ff;
   assign rsp_bound_error = rsp_error_ff;

`ifndef NO_ASSERTIONS
   a_rem_below_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < job_ff.span))
      else $error("partial remainder not below the span");
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bound_error) |-> (rsp_value == '0))
      else $error("bound error response carries a non-zero value");
   a_seed_restart: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> (state_ff == ST_MIX) && (warm_ff == WARM_W'(WARMUP)))
      else $error("seed write did not restart the warm-up");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> (warm_ff == '0))
      else $error("request taken during warm-up");
`endif

endmodule
